// File: rtl/dual_stack_with_search_assert.svh
// Assertion macros for the dual card stack block.
// Depends on nothing; included by the top level only.
`ifndef DUAL_STACK_WITH_SEARCH_ASSERT_SVH
`define DUAL_STACK_WITH_SEARCH_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define DSWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked out of reset
`define DSWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DSWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DSWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/dsws_pkg.sv
// Shared types and codes for the dual card stack block.
// Used by the controller, the datapath and the top level; no dependencies.
package dsws_pkg;

  localparam int FUNC_W = 2;
  localparam int VAL_W  = 4;
  localparam int SUIT_W = 2;
  localparam int CARD_W = VAL_W + SUIT_W;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

  typedef logic [2:0] res_sel_t;

  localparam res_sel_t RES_NONE      = 3'd0;
  localparam res_sel_t RES_PUSH      = 3'd1;
  localparam res_sel_t RES_POP_EMPTY = 3'd2;
  localparam res_sel_t RES_POP       = 3'd3;
  localparam res_sel_t RES_HIT       = 3'd4;
  localparam res_sel_t RES_MISS      = 3'd5;
  localparam res_sel_t RES_NOP       = 3'd6;

  typedef struct packed {
    logic     load;       // latch a new request
    logic     pop_rd;     // drop the top card and read it
    logic     srch_step;  // read the next entry down the stack
    res_sel_t res_sel;    // which result to present
  } dsws_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              empty;
    logic              hit;
    logic              last;
  } dsws_stat_t;

endpackage

// File: rtl/dsws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsws_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dsws_datapath.sv
// Datapath: request registers, stack counts, card store and result registers.
// Depends on dsws_pkg and dsws_ram.
module dsws_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dsws_pkg::FUNC_W-1:0]   in_func,
  input  logic                          in_deck,
  input  logic [dsws_pkg::VAL_W-1:0]    in_card_value,
  input  logic [dsws_pkg::SUIT_W-1:0]   in_card_suit,
  input  dsws_pkg::dsws_cmd_t           cmd,
  output dsws_pkg::dsws_stat_t          stat,
  output logic                          out_strobe,
  output logic [dsws_pkg::VAL_W-1:0]    out_value,
  output logic [dsws_pkg::SUIT_W-1:0]   out_suit,
  output logic [dsws_pkg::CNT_W-1:0]    out_position,
  output logic [dsws_pkg::STAT_W-1:0]   out_status,
  output logic [dsws_pkg::CNT_W-1:0]    out_depth_now
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(2 * STACK_DEPTH);

  logic [dsws_pkg::FUNC_W-1:0] func_r;
  logic                        deck_r;
  logic [dsws_pkg::CARD_W-1:0] card_r;
  logic [CW-1:0]               cnt_r [2];
  logic [CW-1:0]               cnt_nxt;
  logic [CW-1:0]               cmp_r;
  logic [CW-1:0]               cur;
  logic [CW-1:0]               rd_idx;
  logic [AW-1:0]               base;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [dsws_pkg::CARD_W-1:0] rdata;
  logic                        we;
  logic                        full;

  logic                          strobe_r;
  logic [dsws_pkg::VAL_W-1:0]    value_r, value_nxt;
  logic [dsws_pkg::SUIT_W-1:0]   suit_r, suit_nxt;
  logic [dsws_pkg::CNT_W-1:0]    pos_r, pos_nxt;
  logic [dsws_pkg::STAT_W-1:0]   status_r, status_nxt;
  logic [dsws_pkg::CNT_W-1:0]    depth_r, depth_nxt;

  assign cur    = cnt_r[deck_r];
  assign full   = (cur == CW'(STACK_DEPTH));
  assign base   = deck_r ? AW'(STACK_DEPTH) : '0;
  // pop reads with cmp_r still zero, so one index serves pop and search
  assign rd_idx = cur - cmp_r - CW'(1);
  assign raddr  = base + AW'(rd_idx);
  assign waddr  = base + AW'(cur);
  assign we     = (cmd.res_sel == dsws_pkg::RES_PUSH) && !full;

  dsws_ram #(
    .WIDTH (dsws_pkg::CARD_W),
    .DEPTH (2 * STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (card_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign stat.func  = func_r;
  assign stat.empty = (cur == '0);
  assign stat.hit   = (rdata == card_r);
  assign stat.last  = (cmp_r == cur);

  always_comb begin
    cnt_nxt = cur;
    if (we) begin
      cnt_nxt = cur + CW'(1);
    end else if (cmd.pop_rd) begin
      cnt_nxt = cur - CW'(1);
    end
  end

  always_comb begin
    value_nxt  = '0;
    suit_nxt   = '0;
    pos_nxt    = '0;
    status_nxt = dsws_pkg::ST_OK;
    depth_nxt  = dsws_pkg::CNT_W'(cur);
    case (cmd.res_sel)
      dsws_pkg::RES_PUSH: begin
        status_nxt = full ? dsws_pkg::ST_FULL : dsws_pkg::ST_OK;
        depth_nxt  = dsws_pkg::CNT_W'(cnt_nxt);
      end
      dsws_pkg::RES_POP_EMPTY: begin
        status_nxt = dsws_pkg::ST_EMPTY;
      end
      dsws_pkg::RES_POP: begin
        value_nxt = rdata[dsws_pkg::VAL_W-1:0];
        suit_nxt  = rdata[dsws_pkg::CARD_W-1:dsws_pkg::VAL_W];
      end
      dsws_pkg::RES_HIT: begin
        pos_nxt = dsws_pkg::CNT_W'(cmp_r);
      end
      dsws_pkg::RES_MISS: begin
        status_nxt = dsws_pkg::ST_MISS;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r[deck_r] <= cnt_nxt;
      strobe_r      <= (cmd.res_sel != dsws_pkg::RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      deck_r <= in_deck;
      card_r <= {in_card_suit, in_card_value};
      cmp_r  <= '0;
    end else if (cmd.srch_step) begin
      cmp_r <= cmp_r + CW'(1);
    end
    if (cmd.res_sel != dsws_pkg::RES_NONE) begin
      value_r  <= value_nxt;
      suit_r   <= suit_nxt;
      pos_r    <= pos_nxt;
      status_r <= status_nxt;
      depth_r  <= depth_nxt;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_value     = value_r;
  assign out_suit      = suit_r;
  assign out_position  = pos_r;
  assign out_status    = status_r;
  assign out_depth_now = depth_r;

endmodule

// File: rtl/dsws_ctrl.sv
// Controller: sequences push, pop and search over the datapath.
// Depends on dsws_pkg.
module dsws_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  dsws_pkg::dsws_stat_t stat,
  output dsws_pkg::dsws_cmd_t  cmd,
  output logic                 busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POPW = 2'd2;
  localparam logic [1:0] S_SRCH = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.pop_rd    = 1'b0;
    cmd.srch_step = 1'b0;
    cmd.res_sel   = dsws_pkg::RES_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (stat.func)
          dsws_pkg::OP_PUSH: begin
            cmd.res_sel = dsws_pkg::RES_PUSH;
          end
          dsws_pkg::OP_POP: begin
            if (stat.empty) begin
              cmd.res_sel = dsws_pkg::RES_POP_EMPTY;
            end else begin
              cmd.pop_rd = 1'b1;
              state_nxt  = S_POPW;
            end
          end
          dsws_pkg::OP_SEARCH: begin
            if (stat.empty) begin
              cmd.res_sel = dsws_pkg::RES_MISS;
            end else begin
              cmd.srch_step = 1'b1;
              state_nxt     = S_SRCH;
            end
          end
          default: begin
            cmd.res_sel = dsws_pkg::RES_NOP;
          end
        endcase
      end
      S_POPW: begin
        cmd.res_sel = dsws_pkg::RES_POP;
        state_nxt   = S_IDLE;
      end
      S_SRCH: begin
        // compare the entry read last cycle, topmost first
        if (stat.hit) begin
          cmd.res_sel = dsws_pkg::RES_HIT;
          state_nxt   = S_IDLE;
        end else if (stat.last) begin
          cmd.res_sel = dsws_pkg::RES_MISS;
          state_nxt   = S_IDLE;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: rtl/dual_stack_with_search.sv
// Top level of the dual card stack block: controller plus datapath.
// Depends on dsws_pkg, dsws_ctrl, dsws_datapath and the assertion header.
//
// Two LIFO stacks of STACK_DEPTH cards each share one card RAM. A request is
// taken when start is high and busy low; its single result appears on the
// out_ ports for one cycle with out_strobe and must be captured then, as the
// receiver cannot stall the block. A push (or an unused code, an empty pop, a
// search of an empty stack) is answered from state S_EXEC, a pop reads the top
// card in S_EXEC and answers from S_POPW, and a search compares entries in
// S_SRCH, topmost first, until a hit at depth p or a miss over n cards. The
// search walks the stack one entry per cycle through the single RAM read
// port; busy drops in the cycle the result is shown, so the next request may
// be accepted then. No clearing pass is run after reset.
`include "dual_stack_with_search_assert.svh"

module dual_stack_with_search #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [dsws_pkg::FUNC_W-1:0] in_func,
  input  logic                        in_deck,
  input  logic [dsws_pkg::VAL_W-1:0]  in_card_value,
  input  logic [dsws_pkg::SUIT_W-1:0] in_card_suit,
  output logic                        out_strobe,
  output logic [dsws_pkg::VAL_W-1:0]  out_value,
  output logic [dsws_pkg::SUIT_W-1:0] out_suit,
  output logic [dsws_pkg::CNT_W-1:0]  out_position,
  output logic [dsws_pkg::STAT_W-1:0] out_status,
  output logic [dsws_pkg::CNT_W-1:0]  out_depth_now
);

  dsws_pkg::dsws_cmd_t  cmd;
  dsws_pkg::dsws_stat_t stat;

  dsws_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  dsws_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_deck       (in_deck),
    .in_card_value (in_card_value),
    .in_card_suit  (in_card_suit),
    .cmd           (cmd),
    .stat          (stat),
    .out_strobe    (out_strobe),
    .out_value     (out_value),
    .out_suit      (out_suit),
    .out_position  (out_position),
    .out_status    (out_status),
    .out_depth_now (out_depth_now)
  );

  // an accepted request makes the block busy in the following cycle
  `DSWS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // every request finishes with a result as busy drops
  `DSWS_ASSERT_NOW(a_done_strobe, clk, rst_n, $fell(busy), out_strobe)
  // results never come in adjacent cycles
  `DSWS_ASSERT_NEXT(a_strobe_gap, clk, rst_n, out_strobe, !out_strobe)
  // an empty pop always leaves the stack empty
  `DSWS_ASSERT_NOW(a_empty_depth, clk, rst_n,
    out_strobe && (out_status == dsws_pkg::ST_EMPTY), out_depth_now == '0)

endmodule
